### rtl/sac_pkg.sv
// shared types and constants for the set-associative tag lookup block
// no dependencies; imported by every module in rtl/

package sac_pkg;

    // geometry of the tag and state stores
    localparam int MAX_SETS    = 64;
    localparam int MAX_WAYS    = 8;
    localparam int SET_W       = 6;
    localparam int WAY_W       = 3;
    localparam int LINE_W      = SET_W + WAY_W;
    localparam int ADDR_W      = 48;
    localparam int RANK_W      = 3;
    localparam int CNT_W       = 32;
    localparam int CFG_DATA_W  = 4;
    localparam int CFG_INDEX_W = 2;

    // widest set index field that still fits in the set count
    localparam logic [2:0] INDEX_LIMIT = 3'd6;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_POLICY    = 2'd0,
        CFG_OFFSET    = 2'd1,
        CFG_INDEX     = 2'd2,
        CFG_WAYS_USED = 2'd3
    } cfg_reg_t;

    // replacement policy codes
    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    // reset values of the configuration registers
    localparam logic       RST_POLICY    = POLICY_FIFO;
    localparam logic [3:0] RST_OFFSET    = 4'd6;
    localparam logic [2:0] RST_INDEX     = 3'd0;
    localparam logic [3:0] RST_WAYS_USED = 4'd8;

    // per-set state: one valid bit and one recency rank per way
    typedef struct packed {
        logic [MAX_WAYS-1:0]             valid;
        logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
    } set_meta_t;

endpackage

### rtl/sac_addr_split.sv
// splits a byte address into set index and tag from the configured field widths
// depends on sac_pkg

module sac_addr_split (
    input  logic [sac_pkg::ADDR_W-1:0] address,
    input  logic [3:0]                 offset_bits,
    input  logic [2:0]                 index_bits,
    output logic [sac_pkg::SET_W-1:0]  set,
    output logic [sac_pkg::ADDR_W-1:0] tag
);
    import sac_pkg::*;

    logic [2:0]        ib_eff;
    logic [SET_W:0]    set_mask_wide;
    logic [ADDR_W-1:0] above_offset;
    logic [4:0]        tag_shift;

    // clamp index width to what the set count holds
    assign ib_eff = (index_bits > INDEX_LIMIT) ? INDEX_LIMIT : index_bits;

    // set field sits right above the block offset
    assign set_mask_wide = ((SET_W + 1)'(1) << ib_eff) - (SET_W + 1)'(1);
    assign above_offset  = address >> offset_bits;
    assign set           = above_offset[SET_W-1:0] & set_mask_wide[SET_W-1:0];

    // tag is everything above the set field
    assign tag_shift = {1'b0, offset_bits} + {2'b00, ib_eff};
    assign tag       = address >> tag_shift;

endmodule

### rtl/sac_tag_ram.sv
// tag store: one tag per line, addressed by {set, way}, registered read
// depends on sac_pkg

module sac_tag_ram (
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [sac_pkg::LINE_W-1:0] rd_addr,
    output logic [sac_pkg::ADDR_W-1:0] rd_data,
    input  logic                       wr_en,
    input  logic [sac_pkg::LINE_W-1:0] wr_addr,
    input  logic [sac_pkg::ADDR_W-1:0] wr_data
);
    import sac_pkg::*;

    logic [ADDR_W-1:0] tag_mem [MAX_SETS*MAX_WAYS];
    logic [ADDR_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tag_mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= tag_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/sac_meta_ram.sv
// per-set valid and rank store with a row-valid flag per set so reset empties it at once
// depends on sac_pkg

module sac_meta_ram (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rd_en,
    input  logic [sac_pkg::SET_W-1:0] rd_set,
    output sac_pkg::set_meta_t        rd_data,
    input  logic                      wr_en,
    input  logic [sac_pkg::SET_W-1:0] wr_set,
    input  sac_pkg::set_meta_t        wr_data
);
    import sac_pkg::*;

    set_meta_t             meta_mem [MAX_SETS];
    set_meta_t             rd_data_reg;
    logic [MAX_SETS-1:0]   row_valid_reg;
    logic                  rd_row_valid_reg;

    // storage rows, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            meta_mem[wr_set] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= meta_mem[rd_set];
        end
    end

    // row-valid flags: a row never written reads as an empty set
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg    <= '0;
            rd_row_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_set] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_row_valid_reg <= row_valid_reg[rd_set];
            end
        end
    end

    assign rd_data = rd_row_valid_reg ? rd_data_reg : '0;

endmodule

### rtl/set_assoc_cache_tag_lookup.sv
// top level of the set-associative tag lookup: sequencer, scan compare, rank update, counters
// depends on sac_pkg, sac_addr_split, sac_tag_ram, sac_meta_ram

// Write-through, write-allocate tag lookup for up to 64 sets of 8 ways with FIFO or
// LRU replacement. One request is handled at a time: after acceptance the set's state
// row and way 0's tag are read, then a single tag comparator checks one way per cycle
// through the tag memory's read port, stopping at the first hit, then the rank update
// and writes are done in the update stage. The result sits in an output register, so
// the next request is accepted while it waits; the update stage holds only if a second
// result is ready before the first is taken. Reset empties the cache at once through a
// per-set valid flag: there is no clearing pass. Configuration must be written only
// while idle; the block itself does not enforce it.

module set_assoc_cache_tag_lookup (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [sac_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sac_pkg::CFG_DATA_W-1:0]  cfg_data,
    // request channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           action,
    input  logic [sac_pkg::ADDR_W-1:0]     address,
    // result channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           hit,
    output logic                           memory_read,
    output logic                           memory_write,
    output logic [sac_pkg::WAY_W-1:0]      way,
    output logic [sac_pkg::CNT_W-1:0]      hit_total,
    output logic [sac_pkg::CNT_W-1:0]      miss_total,
    output logic [sac_pkg::CNT_W-1:0]      read_total,
    output logic [sac_pkg::CNT_W-1:0]      write_total
);
    import sac_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_TOUCH = 4'b1000
    } state_t;

    // control state
    state_t            state_reg, state_next;
    logic [WAY_W-1:0]  cnt_reg, cnt_next;
    logic              hit_reg, hit_next;
    logic [WAY_W-1:0]  way_reg, way_next;
    logic              free_found_reg, free_found_next;
    logic [WAY_W-1:0]  free_way_reg, free_way_next;
    logic [WAY_W-1:0]  best_reg, best_next;
    logic [CNT_W-1:0]  hit_count_reg, hit_count_next;
    logic [CNT_W-1:0]  miss_count_reg, miss_count_next;
    logic [CNT_W-1:0]  read_count_reg, read_count_next;
    logic [CNT_W-1:0]  write_count_reg, write_count_next;
    logic              out_valid_reg, out_valid_next;

    // configuration
    logic              policy_reg;
    logic [3:0]        offset_bits_reg;
    logic [2:0]        index_bits_reg;
    logic [3:0]        ways_used_reg;

    // request payload held during the lookup
    logic              action_reg;
    logic [SET_W-1:0]  set_reg;
    logic [ADDR_W-1:0] tag_reg;

    // result payload
    logic              hit_out_reg;
    logic              mem_write_out_reg;
    logic [WAY_W-1:0]  way_out_reg;

    logic [SET_W-1:0]  split_set;
    logic [ADDR_W-1:0] split_tag;
    logic [ADDR_W-1:0] tag_rd_data;
    logic [LINE_W-1:0] tag_rd_addr;
    logic              tag_rd_en;
    logic              tag_wr_en;
    set_meta_t         meta;
    set_meta_t         meta_new;
    logic              meta_wr_en;

    logic              accept;
    logic              finish;
    logic [3:0]        ways_eff;
    logic [WAY_W-1:0]  last_way;
    logic              cur_valid;
    logic [RANK_W-1:0] cur_rank;
    logic              cur_match;
    logic [WAY_W-1:0]  victim;

    // field extraction straight from the request ports
    sac_addr_split u_split (
        .address     (address),
        .offset_bits (offset_bits_reg),
        .index_bits  (index_bits_reg),
        .set         (split_set),
        .tag         (split_tag)
    );

    sac_tag_ram u_tag_ram (
        .clk     (clk),
        .rd_en   (tag_rd_en),
        .rd_addr (tag_rd_addr),
        .rd_data (tag_rd_data),
        .wr_en   (tag_wr_en),
        .wr_addr ({set_reg, way_reg}),
        .wr_data (tag_reg)
    );

    sac_meta_ram u_meta_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (state_reg == S_READ),
        .rd_set  (set_reg),
        .rd_data (meta),
        .wr_en   (meta_wr_en),
        .wr_set  (set_reg),
        .wr_data (meta_new)
    );

    // handshakes
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign finish   = (state_reg == S_TOUCH) && !(out_valid_reg && out_stall);

    // ways in use, clamped to 1..MAX_WAYS
    always_comb
    begin
        if (ways_used_reg == 4'd0)
        begin
            ways_eff = 4'd1;
        end
        else if (ways_used_reg > 4'(MAX_WAYS))
        begin
            ways_eff = 4'(MAX_WAYS);
        end
        else
        begin
            ways_eff = ways_used_reg;
        end
    end
    assign last_way = WAY_W'(ways_eff - 4'd1);

    // tag read: way 0 first, then one way ahead of the comparator
    assign tag_rd_en   = (state_reg == S_READ) || (state_reg == S_SCAN);
    assign tag_rd_addr = (state_reg == S_READ) ? {set_reg, WAY_W'(0)}
                                               : {set_reg, cnt_reg + WAY_W'(1)};

    // shared comparator on the way under scan
    assign cur_valid = meta.valid[cnt_reg];
    assign cur_rank  = meta.rank[cnt_reg];
    assign cur_match = cur_valid && (tag_rd_data == tag_reg);

    // recency update: move the chosen way to most recent among the ways in use
    always_comb
    begin
        logic [MAX_WAYS-1:0] others;
        logic                was_valid;
        logic [RANK_W-1:0]   old_rank;
        logic [3:0]          n_others;
        was_valid = meta.valid[way_reg];
        old_rank  = meta.rank[way_reg];
        meta_new  = meta;
        for (int j = 0; j < MAX_WAYS; j++)
        begin
            others[j] = (4'(j) < ways_eff) && (WAY_W'(j) != way_reg) && meta.valid[j];
            if (others[j] && was_valid && (meta.rank[j] > old_rank))
            begin
                meta_new.rank[j] = meta.rank[j] - RANK_W'(1);
            end
        end
        n_others                = 4'($countones(others));
        meta_new.rank[way_reg]  = n_others[RANK_W-1:0];
        meta_new.valid[way_reg] = 1'b1;
    end

    // a hit under fifo leaves the set as it was
    assign meta_wr_en = finish && (!hit_reg || (policy_reg == POLICY_LRU));
    assign tag_wr_en  = finish && !hit_reg;

    // victim choice once the scan ends with a miss
    assign victim = free_found_next ? free_way_next : best_next;

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        hit_next         = hit_reg;
        way_next         = way_reg;
        free_found_next  = free_found_reg;
        free_way_next    = free_way_reg;
        best_next        = best_reg;
        hit_count_next   = hit_count_reg;
        miss_count_next  = miss_count_reg;
        read_count_next  = read_count_reg;
        write_count_next = write_count_reg;
        out_valid_next   = out_valid_reg && out_stall;

        // first invalid way and lowest rank seen so far
        if (state_reg == S_SCAN)
        begin
            if (!free_found_reg && !cur_valid)
            begin
                free_found_next = 1'b1;
                free_way_next   = cnt_reg;
            end
            if (cnt_reg == WAY_W'(0))
            begin
                best_next = cnt_reg;
            end
            else if (cur_rank < meta.rank[best_reg])
            begin
                best_next = cnt_reg;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cnt_next        = '0;
                    free_found_next = 1'b0;
                    state_next      = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (cur_match)
                begin
                    hit_next   = 1'b1;
                    way_next   = cnt_reg;
                    state_next = S_TOUCH;
                end
                else if (cnt_reg == last_way)
                begin
                    hit_next   = 1'b0;
                    way_next   = victim;
                    state_next = S_TOUCH;
                end
                else
                begin
                    cnt_next = cnt_reg + WAY_W'(1);
                end
            end
            S_TOUCH:
            begin
                if (finish)
                begin
                    if (hit_reg)
                    begin
                        hit_count_next = hit_count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        miss_count_next = miss_count_reg + CNT_W'(1);
                        read_count_next = read_count_reg + CNT_W'(1);
                    end
                    if (action_reg)
                    begin
                        write_count_next = write_count_reg + CNT_W'(1);
                    end
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            hit_reg         <= 1'b0;
            way_reg         <= '0;
            free_found_reg  <= 1'b0;
            free_way_reg    <= '0;
            best_reg        <= '0;
            hit_count_reg   <= '0;
            miss_count_reg  <= '0;
            read_count_reg  <= '0;
            write_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            hit_reg         <= hit_next;
            way_reg         <= way_next;
            free_found_reg  <= free_found_next;
            free_way_reg    <= free_way_next;
            best_reg        <= best_next;
            hit_count_reg   <= hit_count_next;
            miss_count_reg  <= miss_count_next;
            read_count_reg  <= read_count_next;
            write_count_reg <= write_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg      <= RST_POLICY;
            offset_bits_reg <= RST_OFFSET;
            index_bits_reg  <= RST_INDEX;
            ways_used_reg   <= RST_WAYS_USED;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_POLICY:    policy_reg      <= cfg_data[0];
                CFG_OFFSET:    offset_bits_reg <= cfg_data[3:0];
                CFG_INDEX:     index_bits_reg  <= cfg_data[2:0];
                CFG_WAYS_USED: ways_used_reg   <= cfg_data[3:0];
            endcase
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= action;
            set_reg    <= split_set;
            tag_reg    <= split_tag;
        end
        if (finish)
        begin
            hit_out_reg       <= hit_reg;
            mem_write_out_reg <= action_reg;
            way_out_reg       <= way_reg;
        end
    end

    // result ports
    assign out_valid    = out_valid_reg;
    assign hit          = hit_out_reg;
    assign memory_read  = !hit_out_reg;
    assign memory_write = mem_write_out_reg;
    assign way          = way_out_reg;
    assign hit_total    = hit_count_reg;
    assign miss_total   = miss_count_reg;
    assign read_total   = read_count_reg;
    assign write_total  = write_count_reg;

endmodule
